FILE: sv/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("check failed");
`define CHK_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

FILE: sv/lsrs_pkg.sv
package lsrs_pkg;
	localparam int unsigned MaxSamples = 1024;
	localparam logic [10:0] CountLimit = 11'd2047;
	localparam logic [10:0] MaxCount = (MaxSamples < 2047) ? 11'(MaxSamples) : CountLimit;
	localparam logic signed [26:0] SumMax = 27'sd67108863;
	localparam logic signed [26:0] SumMin = -27'sd67108864;
	localparam logic signed [31:0] Cx0 = 32'sd652032874;
	localparam logic [14:0] Bias03 = 15'd9830;
	localparam logic [2:0] ADDR_START = 3'd0;
	localparam logic [2:0] ADDR_STEP = 3'd4;

	function automatic logic [31:0] atan_lut(input logic [3:0] i);
		case (i)
			4'd0: atan_lut = 32'h20000000;
			4'd1: atan_lut = 32'h12E4051E;
			4'd2: atan_lut = 32'h09FB385B;
			4'd3: atan_lut = 32'h051111D4;
			4'd4: atan_lut = 32'h028B0D43;
			4'd5: atan_lut = 32'h0145D7E1;
			4'd6: atan_lut = 32'h00A2F61E;
			4'd7: atan_lut = 32'h00517C55;
			4'd8: atan_lut = 32'h0028BE53;
			4'd9: atan_lut = 32'h00145F2F;
			4'd10: atan_lut = 32'h000A2F98;
			4'd11: atan_lut = 32'h000517CC;
			4'd12: atan_lut = 32'h00028BE6;
			4'd13: atan_lut = 32'h000145F3;
			4'd14: atan_lut = 32'h0000A2FA;
			default: atan_lut = 32'h0000517D;
		endcase
	endfunction

	typedef struct packed {
		logic load;     // latch sample, start weight div and cordic
		logic step;     // one div bit, and one cordic rotation while it_q < 16
		logic mul;      // latch cos and sin for the products
		logic acc;      // update sums, count and beam angle
		logic mstart;   // start mean divisions
		logic mstep;
		logic finish;   // form result, clear scan
	} lsrs_cmd_t;

	typedef struct packed {
		logic [10:0] count;
	} lsrs_sts_t;
endpackage

FILE: sv/lsrs_if.sv
interface lsrs_in_if;
	logic valid;
	logic ready;
	logic [15:0] range_sample;
	logic last_sample;
	modport source (output valid, range_sample, last_sample, input ready);
	modport sink (input valid, range_sample, last_sample, output ready);
endinterface

interface lsrs_out_if;
	logic valid;
	logic ready;
	logic [14:0] linear_speed;
	logic signed [15:0] angular_speed;
	modport source (output valid, linear_speed, angular_speed, input ready);
	modport sink (input valid, linear_speed, angular_speed, output ready);
endinterface

FILE: sv/laser_scan_repulsive_steering.sv
// channel  dir  payload
// in_ch    in   range_sample[15:0], last_sample
// out_ch   out  linear_speed[14:0], angular_speed[15:0]
// apb      in   start_angle @0x0, angle_step @0x4
// a sample runs the serial weight divider (cordic runs alongside), then product and accumulate;
// a marked sample then adds a serial mean division
// the result waits in an output register; the next item is held off only until it is taken
// reset clears the scan state and sets start_angle to -32768, angle_step to 64
`include "assert_macros.svh"
module laser_scan_repulsive_steering import lsrs_pkg::*; (
	input logic clk,
	input logic arst_n,
	lsrs_in_if.sink in_ch,
	lsrs_out_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic signed [15:0] start_q, step_q;
	lsrs_cmd_t cmd;
	lsrs_sts_t sts;
	logic emit;
	logic ovalid_q;
	logic [14:0] lin;
	logic signed [15:0] ang;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= -16'sd32768;
			step_q <= 16'sd64;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_START) start_q <= pwdata[15:0];
			if (paddr == ADDR_STEP) step_q <= pwdata[15:0];
		end
	end
	always_comb begin
		case (paddr)
			ADDR_START: prdata = {{16{start_q[15]}}, start_q};
			ADDR_STEP: prdata = {{16{step_q[15]}}, step_q};
			default: prdata = '0;
		endcase
	end

	lsrs_ctrl u_ctrl (.clk, .arst_n, .in_ch, .out_busy(ovalid_q && !out_ch.ready),
		.sts, .cmd, .emit);
	lsrs_datapath u_dp (.clk, .arst_n, .cmd, .range_sample(in_ch.range_sample),
		.start_angle(start_q), .angle_step(step_q), .sts, .lin_q(lin), .ang_q(ang));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (emit) ovalid_q <= 1'b1;
		else if (out_ch.ready) ovalid_q <= 1'b0;
	end
	assign out_ch.valid = ovalid_q;
	assign out_ch.linear_speed = lin;
	assign out_ch.angular_speed = ang;

	`CHK_IMPL(a_lin_range, ovalid_q, lin <= 15'd19660)
	`CHK_NEXT(a_emit_valid, emit, ovalid_q)
endmodule

FILE: sv/lsrs_datapath.sv
module lsrs_datapath import lsrs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input lsrs_cmd_t cmd,
	input logic [15:0] range_sample,
	input logic signed [15:0] start_angle,
	input logic signed [15:0] angle_step,
	output lsrs_sts_t sts,
	output logic [14:0] lin_q,
	output logic signed [15:0] ang_q
);
	logic [10:0] count_q;
	logic signed [15:0] beam_q;
	logic signed [26:0] fsum_q, tsum_q;
	logic signed [15:0] ang_now;
	// weight divider: 2^31 / (65536 + d*d), restoring, 32 quotient bits
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0] it_q;
	logic signed [31:0] x_q, y_q, z_q;
	logic flip_q;
	logic signed [16:0] cos_q, sin_q;
	logic signed [33:0] pc_q, ps_q;
	logic [31:0] dd;
	logic [33:0] rtry;
	logic [32:0] rsh;
	logic [3:0] ci;
	logic signed [31:0] xs, ys;
	logic signed [15:0] anorm;
	logic aflip;
	logic signed [16:0] cx, sy, wq;

	assign sts.count = count_q;
	assign ang_now = (count_q == 11'd0) ? start_angle : beam_q;
	assign dd = 32'(range_sample) * 32'(range_sample);
	always_comb begin
		aflip = 1'b0;
		anorm = ang_now;
		if (ang_now > 16'sd16384) begin
			anorm = ang_now - 16'sh8000;
			aflip = 1'b1;
		end else if (ang_now < -16'sd16384) begin
			anorm = ang_now + 16'sh8000;
			aflip = 1'b1;
		end
	end
	// 2^31 has its only one bit at the top, brought in on the first step
	assign rsh = {rem_q[31:0], (it_q == 5'd0)};
	assign rtry = {1'b0, rsh} - {1'b0, den_q};
	assign ci = it_q[3:0];
	assign xs = x_q >>> ci;
	assign ys = y_q >>> ci;
	assign cx = 17'(x_q >>> 15);
	assign sy = 17'(y_q >>> 15);
	assign wq = 17'(quo_q);

	// mean divider: |sum| / count, 27 bits
	logic [26:0] fm_q, tm_q;
	logic [10:0] fr_q, tr_q;
	logic fneg_q, tneg_q;
	logic [26:0] fabs, tabs;
	logic [11:0] frs, trs;
	logic [11:0] ftry, ttry;
	logic signed [27:0] fmean, tmean;
	logic signed [33:0] fnew, tnew;

	assign fabs = fsum_q[26] ? 27'(-fsum_q) : 27'(fsum_q);
	assign tabs = tsum_q[26] ? 27'(-tsum_q) : 27'(tsum_q);
	assign frs = {fr_q, fm_q[26]};
	assign trs = {tr_q, tm_q[26]};
	assign ftry = frs - {1'b0, count_q};
	assign ttry = trs - {1'b0, count_q};
	assign fmean = fneg_q ? -$signed({1'b0, fm_q}) : $signed({1'b0, fm_q});
	assign tmean = tneg_q ? -$signed({1'b0, tm_q}) : $signed({1'b0, tm_q});
	assign fnew = 34'(fsum_q) - (pc_q >>> 15);
	assign tnew = 34'(tsum_q) - (ps_q >>> 15);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fsum_q <= '0;
			tsum_q <= '0;
		end else if (cmd.acc) begin
			count_q <= count_q + 11'd1;
			fsum_q <= (fnew > 34'(SumMax)) ? SumMax : (fnew < 34'(SumMin)) ? SumMin : 27'(fnew);
			tsum_q <= (tnew > 34'(SumMax)) ? SumMax : (tnew < 34'(SumMin)) ? SumMin : 27'(tnew);
		end else if (cmd.finish) begin
			count_q <= '0;
			fsum_q <= '0;
			tsum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			den_q <= 33'h10000 + 33'(dd);
			rem_q <= '0;
			quo_q <= '0;
			it_q <= '0;
			x_q <= Cx0;
			y_q <= '0;
			z_q <= 32'(anorm) <<< 16;
			flip_q <= aflip;
		end else if (cmd.step) begin
			if (!rtry[33]) begin
				rem_q <= rtry[32:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rsh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
			it_q <= it_q + 5'd1;
			if (it_q < 5'd16) begin
				if (!z_q[31]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - $signed(atan_lut(ci));
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + $signed(atan_lut(ci));
				end
			end
		end
		if (cmd.mul) begin
			cos_q <= flip_q ? -cx : cx;
			sin_q <= flip_q ? -sy : sy;
		end
		if (cmd.acc) begin
			beam_q <= ang_now + angle_step;
		end else if (cmd.finish) begin
			beam_q <= start_angle;
		end
		if (cmd.mstart) begin
			fm_q <= fabs;
			tm_q <= tabs;
			fneg_q <= fsum_q[26];
			tneg_q <= tsum_q[26];
			fr_q <= '0;
			tr_q <= '0;
		end else if (cmd.mstep) begin
			if (!ftry[11]) begin
				fr_q <= ftry[10:0];
				fm_q <= {fm_q[25:0], 1'b1};
			end else begin
				fr_q <= frs[10:0];
				fm_q <= {fm_q[25:0], 1'b0};
			end
			if (!ttry[11]) begin
				tr_q <= ttry[10:0];
				tm_q <= {tm_q[25:0], 1'b1};
			end else begin
				tr_q <= trs[10:0];
				tm_q <= {tm_q[25:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			if (count_q == 11'd0) begin
				lin_q <= Bias03;
				ang_q <= '0;
			end else begin
				lin_q <= (fmean > 28'sd9830) ? 15'd19660 :
					(fmean < -28'sd9830) ? 15'd0 : 15'(fmean + 28'sd9830);
				ang_q <= (tmean > 28'sd32767) ? 16'sh7fff :
					(tmean < -28'sd32768) ? 16'sh8000 : 16'(tmean);
			end
		end
	end

	// products are registered from the latched cos and sin, landing in the cycle after they are latched
	always_ff @(posedge clk) begin
		pc_q <= cos_q * wq;
		ps_q <= sin_q * wq;
	end
endmodule

FILE: sv/lsrs_ctrl.sv
`include "assert_macros.svh"
module lsrs_ctrl import lsrs_pkg::*; (
	input logic clk,
	input logic arst_n,
	lsrs_in_if.sink in_ch,
	input logic out_busy,
	input lsrs_sts_t sts,
	output lsrs_cmd_t cmd,
	output logic emit
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RUN = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_PROD = 3'd3;
	localparam logic [2:0] S_ACC = 3'd4;
	localparam logic [2:0] S_MEAN = 3'd5;
	localparam logic [2:0] S_FIN = 3'd6;

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic last_q;
	logic take;

	assign in_ch.ready = (state_q == S_IDLE) && !out_busy;
	assign take = in_ch.valid && in_ch.ready;

	always_comb begin
		cmd = '0;
		cmd.load = take;
		cmd.step = (state_q == S_RUN);
		cmd.mul = (state_q == S_MUL);
		cmd.acc = (state_q == S_ACC);
		cmd.mstart = (state_q == S_ACC) ? 1'b0 : 1'b0;
		cmd.mstep = (state_q == S_MEAN) && (cnt_q != 5'd0);
		cmd.finish = (state_q == S_FIN);
		if (state_q == S_MEAN && cnt_q == 5'd0) cmd.mstart = 1'b1;
	end
	assign emit = (state_q == S_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						last_q <= in_ch.last_sample;
						cnt_q <= '0;
						state_q <= (sts.count < MaxCount) ? S_RUN : S_MEAN;
						if (!(sts.count < MaxCount) && !in_ch.last_sample) state_q <= S_IDLE;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= S_MUL;
				end
				S_MUL: state_q <= S_PROD;
				S_PROD: state_q <= S_ACC;
				S_ACC: begin
					cnt_q <= '0;
					state_q <= last_q ? S_MEAN : S_IDLE;
				end
				S_MEAN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd27) state_q <= S_FIN;
				end
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CHK_IMPL(a_ready_idle, in_ch.ready, state_q == S_IDLE)
	`CHK_NEXT(a_fin_idle, state_q == S_FIN, state_q == S_IDLE)
	`CHK_NEXT(a_acc_next, state_q == S_PROD, state_q == S_ACC)
endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
	import lsrs_pkg::*;

	typedef struct {
		logic [15:0] range_val;
		logic mark;
		logic known;
		logic [14:0] lin_exp;
		logic signed [15:0] ang_exp;
	} scan_row_t;

	typedef struct {
		logic [14:0] lin;
		logic signed [15:0] ang;
	} steer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	lsrs_in_if in_ch();
	lsrs_out_if out_ch();

	laser_scan_repulsive_steering DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	initial begin
		#40000000;
		$display("laser_scan_repulsive_steering test failed");
		$finish;
	end

	// predictor state
	logic signed [15:0] cfg_start = -16'sd32768;
	logic signed [15:0] cfg_step = 16'sd64;
	logic [10:0] n_beams = '0;
	logic signed [15:0] next_angle = -16'sd32768;
	longint fwd_acc = 0;
	longint turn_acc = 0;

	steer_t steer_q[$];
	int errors = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int hold_cycles = 0;
	bit stream_done = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_sum(input longint v);
		if (v > 67108863) return 67108863;
		if (v < -67108864) return -67108864;
		return v;
	endfunction

	function automatic void beam_trig(input int a_in, output longint c, output longint s);
		int a;
		bit flip;
		longint x, y, z, t;
		longint atan_q[16];
		a = a_in;
		flip = 0;
		atan_q = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
			64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
			64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
			64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
		if (a > 16384) begin
			a -= 32768;
			flip = 1;
		end else if (a < -16384) begin
			a += 32768;
			flip = 1;
		end
		x = 652032874;
		y = 0;
		z = longint'(a) * 65536;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				t = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				x = t;
				z -= atan_q[i];
			end else begin
				t = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				x = t;
				z += atan_q[i];
			end
		end
		x = floor_shift(x, 15);
		y = floor_shift(y, 15);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint trunc_mean(input longint sum, input int n);
		longint m;
		if (n == 0) return 0;
		m = (sum < 0 ? -sum : sum) / n;
		return sum < 0 ? -m : m;
	endfunction

	function automatic bit steer_predict(input logic [15:0] d, input logic mark, output steer_t r);
		longint c, s, w, lin, ang;
		logic signed [15:0] a;
		if (n_beams < MaxCount) begin
			a = (n_beams == 0) ? cfg_start : next_angle;
			w = (64'd1 << 31) / (65536 + longint'(d) * longint'(d));
			beam_trig(int'(a), c, s);
			fwd_acc = clamp_sum(fwd_acc - floor_shift(c * w, 15));
			turn_acc = clamp_sum(turn_acc - floor_shift(s * w, 15));
			next_angle = a + cfg_step;
			n_beams++;
		end
		if (!mark) return 0;
		lin = trunc_mean(fwd_acc, int'(n_beams));
		ang = trunc_mean(turn_acc, int'(n_beams));
		if (lin > 9830) lin = 9830;
		if (lin < -9830) lin = -9830;
		if (ang > 32767) ang = 32767;
		if (ang < -32768) ang = -32768;
		r.lin = 15'(lin + 9830);
		r.ang = 16'(ang);
		n_beams = '0;
		next_angle = cfg_start;
		fwd_acc = 0;
		turn_acc = 0;
		return 1;
	endfunction

	task automatic apb_write(input logic [2:0] addr, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {{16{val[15]}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_START) cfg_start = val;
		else cfg_step = val;
		if (n_beams == 0) next_angle = cfg_start;
	endtask

	task automatic send_sample(input logic [15:0] d, input logic mark);
		steer_t r;
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.range_sample <= d;
		in_ch.last_sample <= mark;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (steer_predict(d, mark, r)) steer_q.push_back(r);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		while (steer_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		if (steer_q.size() != 0) begin
			report("missing items", steer_q.size(), 0);
			steer_q.delete();
		end
		repeat (120) @(posedge clk);
	endtask

	// random scans: mostly short, optionally one first scan long enough to pass the sample cap
	task automatic random_scans(input int items, input bit with_long);
		int len, sent;
		logic [15:0] d;
		sent = 0;
		while (sent < items) begin
			len = (with_long && sent == 0) ? $urandom_range(1030, 1040) : $urandom_range(1, 12);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(3))
					0: d = $urandom;
					1: d = $urandom_range(0, 511);
					2: d = $urandom_range(0, 3) ? 16'($urandom_range(0, 64)) : 16'hFFFF;
					default: d = $urandom_range(256, 4096);
				endcase
				send_sample(d, k == len - 1);
			end
			sent += (with_long && sent == 0) ? 1 : len;
		end
	endtask

	// receiver
	always @(posedge clk) begin
		steer_t e;
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (steer_q.size() == 0) begin
				report("unexpected item", out_ch.linear_speed, -1);
			end else begin
				e = steer_q.pop_front();
				if (out_ch.linear_speed !== e.lin)
					report("linear_speed", out_ch.linear_speed, e.lin);
				if (out_ch.angular_speed !== e.ang)
					report("angular_speed", out_ch.angular_speed, e.ang);
			end
		end
	end

	initial begin
		scan_row_t rows[$];
		scan_row_t row;
		steer_t r;
		int n_before;
		in_ch.valid = 1'b0;
		in_ch.range_sample = '0;
		in_ch.last_sample = 1'b0;
		out_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero range at reset angle (-half turn) gives cos=-1, pushes forward
		rows.push_back('{16'h0000, 1'b1, 1'b0, 15'd0, 16'sd0});
		// far obstacle: negligible weight, result is the bias
		rows.push_back('{16'hFFFF, 1'b1, 1'b1, 15'd9830, 16'sd0});
		rows.push_back('{16'h0001, 1'b0, 1'b0, 15'd0, 16'sd0});
		rows.push_back('{16'h8000, 1'b0, 1'b0, 15'd0, 16'sd0});
		rows.push_back('{16'h0100, 1'b1, 1'b0, 15'd0, 16'sd0});
		rows.push_back('{16'h00FF, 1'b0, 1'b0, 15'd0, 16'sd0});
		rows.push_back('{16'h7FFF, 1'b0, 1'b0, 15'd0, 16'sd0});
		rows.push_back('{16'hAAAA, 1'b0, 1'b0, 15'd0, 16'sd0});
		rows.push_back('{16'h5555, 1'b1, 1'b0, 15'd0, 16'sd0});
		foreach (rows[i]) begin
			row = rows[i];
			n_before = steer_q.size();
			send_sample(row.range_val, row.mark);
			if (row.known && steer_q.size() > n_before) begin
				r = steer_q[$];
				if (r.lin !== row.lin_exp) report("table linear_speed", r.lin, row.lin_exp);
				if (r.ang !== row.ang_exp) report("table angular_speed", r.ang, row.ang_exp);
			end
		end
		drain();

		// front-facing beams at zero range: forward mean hits the clamp
		apb_write(ADDR_START, 16'sd0);
		apb_write(ADDR_STEP, 16'sd0);
		for (int k = 0; k < 4; k++) send_sample(16'h0000, k == 3);
		drain();
		apb_write(ADDR_START, 16'sd16384);
		apb_write(ADDR_STEP, 16'sh7FFF);
		for (int k = 0; k < 6; k++) send_sample(16'h0000, k == 5);
		drain();
		apb_write(ADDR_START, 16'sh7FFF);
		apb_write(ADDR_STEP, 16'sh8000);
		for (int k = 0; k < 5; k++) send_sample(16'($urandom_range(0, 200)), k == 4);
		drain();

		// pressure: long receiver hold while scans keep coming
		hold_cycles = 2000;
		apb_write(ADDR_START, 16'($urandom));
		apb_write(ADDR_STEP, 16'($urandom));
		for (int k = 0; k < 30; k++) send_sample(16'($urandom), $urandom_range(1));
		send_sample(16'd10, 1'b1);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			in_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 61 : 0;
			out_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 12 : 0;
			apb_write(ADDR_START, (ph == 2) ? 16'sh8000 : 16'($urandom));
			apb_write(ADDR_STEP, (ph == 2) ? 16'sh7FFF : 16'($urandom_range(0, 2048)));
			random_scans(200, ph == 2);
			drain();
		end

		if (errors == 0)
			$display("laser_scan_repulsive_steering test passed");
		else
			$display("laser_scan_repulsive_steering test failed");
		$finish;
	end
endmodule
